// ----- rtl/core/flow_table_classifier_top_defines.svh -----
// ----------------------------------------------------------------------------
// Flow table classifier assertion macros
// Shared assertion forms for the classifier top level.
// ----------------------------------------------------------------------------
`ifndef FLOW_TABLE_CLASSIFIER_TOP_DEFINES_SVH
`define FLOW_TABLE_CLASSIFIER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FTC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FTC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/ftc_pkg.sv -----
// ----------------------------------------------------------------------------
// Flow table classifier package
// Types, codes and default sizes shared by the classifier modules.
// ----------------------------------------------------------------------------
package ftc_pkg;

	localparam int TABLE_SLOTS_DEF     = 16;
	localparam int PACKET_BYTES_DEF    = 128;
	localparam int MAX_MATCH_BYTES_DEF = 8;

	typedef enum logic [1:0] {
		KIND_ADD    = 2'd0,
		KIND_REMOVE = 2'd1,
		KIND_BYTE   = 2'd2,
		KIND_TICK   = 2'd3
	} ftc_kind_t;

	typedef enum logic [2:0] {
		OP_EQ = 3'd0,
		OP_NE = 3'd1,
		OP_LT = 3'd2,
		OP_LE = 3'd3,
		OP_GT = 3'd4,
		OP_GE = 3'd5
	} ftc_op_t;

	typedef enum logic [2:0] {
		ST_ADDED     = 3'd0,
		ST_DUPLICATE = 3'd1,
		ST_FULL      = 3'd2,
		ST_REMOVED   = 3'd3,
		ST_NOT_FOUND = 3'd4,
		ST_HIT       = 3'd5,
		ST_NO_MATCH  = 3'd6
	} ftc_status_t;

	typedef struct packed {
		ftc_kind_t   kind;
		logic        list_sel;
		logic [2:0]  compare_op;
		logic [7:0]  byte_offset;
		logic [3:0]  match_len;
		logic        needs_ext;
		logic [63:0] match_value;
		logic [2:0]  action_code;
		logic [15:0] lifetime;
		logic [7:0]  pkt_byte;
		logic [7:0]  ext_len;
		logic        last;
	} ftc_item_t;

	typedef struct packed {
		ftc_status_t status;
		logic [3:0]  hit_slot;
		logic [2:0]  hit_action;
	} ftc_result_t;

	typedef struct packed {
		logic [2:0] action;
		logic       ext;
		logic [3:0] len;
		logic [7:0] offset;
		logic [2:0] op;
	} ftc_fields_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DUP,
		S_ADD_WR,
		S_REM,
		S_TICK,
		S_LK_SLOT,
		S_LK_BYTE,
		S_LK_CMP,
		S_LK_END,
		S_RESP
	} ftc_state_t;

	typedef enum logic [3:0] {
		DP_NONE,
		DP_LATCH,
		DP_DUP,
		DP_ADD_WR,
		DP_REM,
		DP_TICK,
		DP_LK_SLOT,
		DP_LK_BYTE,
		DP_LK_CMP,
		DP_LK_END
	} ftc_dp_op_t;

	typedef struct packed {
		ftc_dp_op_t op;
		logic       load_out;
	} ftc_cmd_t;

	typedef struct packed {
		logic idx_last;
		logic dup_hit;
		logic slot_ok;
		logic bytes_done;
	} ftc_stat_t;

endpackage

// ----- rtl/core/ftc_stream_if.sv -----
// ----------------------------------------------------------------------------
// Flow table classifier stream interface
// Valid and ready handshake with a typed payload.
// ----------------------------------------------------------------------------
interface ftc_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/ftc_ram.sv -----
// ----------------------------------------------------------------------------
// Flow table classifier RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module ftc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- rtl/core/ftc_ctrl.sv -----
// ----------------------------------------------------------------------------
// Flow table classifier controller
// Sequences table scans, packet lookup and response delivery.
// ----------------------------------------------------------------------------
module ftc_ctrl import ftc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  ftc_kind_t in_kind,
	input  logic      in_last,
	output logic      in_ready,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	input  ftc_stat_t stat,
	output ftc_cmd_t  cmd
);
	ftc_state_t state_q, state_d;
	logic       rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d      = state_q;
		cmd.op       = DP_NONE;
		cmd.load_out = 1'b0;
		in_ready     = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op = DP_LATCH;
					case (in_kind)
						KIND_ADD:    state_d = S_DUP;
						KIND_REMOVE: state_d = S_REM;
						KIND_TICK:   state_d = S_TICK;
						default:     state_d = in_last ? S_LK_SLOT : S_IDLE;
					endcase
				end
			end
			S_DUP: begin
				cmd.op = DP_DUP;
				if (stat.dup_hit) begin
					state_d = S_RESP;
				end else if (stat.idx_last) begin
					state_d = S_ADD_WR;
				end
			end
			S_ADD_WR: begin
				cmd.op  = DP_ADD_WR;
				state_d = S_RESP;
			end
			S_REM: begin
				cmd.op = DP_REM;
				if (stat.idx_last) begin
					state_d = S_RESP;
				end
			end
			S_TICK: begin
				cmd.op = DP_TICK;
				if (stat.idx_last) begin
					state_d = S_IDLE;
				end
			end
			S_LK_SLOT: begin
				cmd.op = DP_LK_SLOT;
				if (stat.slot_ok) begin
					state_d = S_LK_BYTE;
				end else if (stat.idx_last) begin
					state_d = S_LK_END;
				end
			end
			S_LK_BYTE: begin
				cmd.op = DP_LK_BYTE;
				if (stat.bytes_done) begin
					state_d = S_LK_CMP;
				end
			end
			S_LK_CMP: begin
				cmd.op  = DP_LK_CMP;
				state_d = stat.idx_last ? S_LK_END : S_LK_SLOT;
			end
			S_LK_END: begin
				cmd.op  = DP_LK_END;
				state_d = S_RESP;
			end
			S_RESP: begin
				if (!rsp_valid_q || rsp_ready) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign rsp_valid = rsp_valid_q;
endmodule

// ----- rtl/core/ftc_dp.sv -----
// ----------------------------------------------------------------------------
// Flow table classifier datapath
// Rule table, packet buffer, scan index, byte gather and compare.
// ----------------------------------------------------------------------------
module ftc_dp import ftc_pkg::*; #(
	parameter int TABLE_SLOTS     = TABLE_SLOTS_DEF,
	parameter int PACKET_BYTES    = PACKET_BYTES_DEF,
	parameter int MAX_MATCH_BYTES = MAX_MATCH_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  ftc_item_t   item,
	input  logic        refresh,
	input  ftc_cmd_t    cmd,
	output ftc_stat_t   stat,
	output ftc_result_t result
);
	localparam int SW   = $clog2(TABLE_SLOTS);
	localparam int CNTW = $clog2(TABLE_SLOTS + 1);
	localparam int AW   = $clog2(PACKET_BYTES);
	localparam int PCW  = $clog2(PACKET_BYTES + 1);

	logic [TABLE_SLOTS-1:0] slot_valid_q;
	logic [TABLE_SLOTS-1:0] slot_list_q;
	logic [SW-1:0]          slot_order_q  [TABLE_SLOTS];
	logic [63:0]            slot_rule_q   [TABLE_SLOTS];
	ftc_fields_t            slot_fields_q [TABLE_SLOTS];
	logic [15:0]            slot_reload_q [TABLE_SLOTS];
	logic [15:0]            slot_rem_q    [TABLE_SLOTS];
	logic [CNTW-1:0]        ins_cnt_q;
	logic [PCW-1:0]         pkt_cnt_q;

	logic        lsel_q;
	ftc_fields_t fld_q;
	logic [63:0] val_q;
	logic [15:0] life_q;
	logic [7:0]  extl_q;

	logic [SW-1:0] idx_q;
	logic          free_vld_q;
	logic [SW-1:0] free_slot_q;
	logic          found_q;
	logic          best_vld_q;
	logic [SW-1:0] best_slot_q;
	logic [SW-1:0] best_ord_q;
	logic [2:0]    best_act_q;
	logic [15:0]   best_reload_q;
	logic [AW-1:0] ptr_q;
	logic [3:0]    kcnt_q;
	logic [63:0]   pv_q;
	ftc_result_t   res_q;
	ftc_result_t   out_q;

	logic [3:0]    len_n;
	logic [63:0]   val_n;
	ftc_fields_t   fld_n;
	logic          cur_valid;
	ftc_fields_t   cur_fld;
	logic [SW-1:0] cur_order;
	logic [15:0]   cur_rem;
	logic [15:0]   rem_dec;
	logic          match_cur;
	logic          tick_live;
	logic          free_now;
	logic          add_now;
	logic          byte_wr;
	logic          holds;
	logic [8:0]    pos;
	logic [9:0]    end_pos;
	logic [AW-1:0] ram_raddr;
	logic [7:0]    ram_rdata;

	function automatic logic op_holds(logic [2:0] op, logic [63:0] r, logic [63:0] p);
		case (ftc_op_t'(op))
			OP_EQ:   return r == p;
			OP_NE:   return r != p;
			OP_LT:   return r < p;
			OP_LE:   return r <= p;
			OP_GT:   return r > p;
			OP_GE:   return r >= p;
			default: return 1'b0;
		endcase
	endfunction

	always_comb begin
		if (item.match_len == 4'd0) begin
			len_n = 4'd1;
		end else if (item.match_len > 4'(MAX_MATCH_BYTES)) begin
			len_n = 4'(MAX_MATCH_BYTES);
		end else begin
			len_n = item.match_len;
		end
		for (int b = 0; b < 8; b++) begin
			val_n[8*b +: 8] = (b < int'(len_n)) ? item.match_value[8*b +: 8] : 8'd0;
		end
		fld_n.action = item.action_code;
		fld_n.ext    = item.needs_ext;
		fld_n.len    = len_n;
		fld_n.offset = item.byte_offset;
		fld_n.op     = item.compare_op;
	end

	assign cur_valid = slot_valid_q[idx_q];
	assign cur_fld   = slot_fields_q[idx_q];
	assign cur_order = slot_order_q[idx_q];
	assign cur_rem   = slot_rem_q[idx_q];
	assign rem_dec   = (cur_rem == 16'd0) ? 16'd0 : cur_rem - 16'd1;
	assign match_cur = cur_valid && (cur_fld == fld_q) && (slot_rule_q[idx_q] == val_q);
	assign tick_live = cur_valid && (slot_reload_q[idx_q] != 16'd0);
	assign free_now  = ((cmd.op == DP_REM) && match_cur)
		|| ((cmd.op == DP_TICK) && tick_live && (rem_dec == 16'd0));
	assign add_now   = (cmd.op == DP_ADD_WR) && free_vld_q;
	assign byte_wr   = (cmd.op == DP_LATCH) && (item.kind == KIND_BYTE)
		&& (pkt_cnt_q < PCW'(PACKET_BYTES));
	assign pos       = 9'(cur_fld.offset) + (cur_fld.ext ? 9'(extl_q) : 9'd0);
	assign end_pos   = 10'(pos) + 10'(cur_fld.len);
	assign holds     = op_holds(cur_fld.op, slot_rule_q[idx_q], pv_q);
	assign ram_raddr = (cmd.op == DP_LK_SLOT) ? AW'(pos) : ptr_q;

	assign stat.idx_last   = (idx_q == SW'(TABLE_SLOTS - 1));
	assign stat.dup_hit    = match_cur && (slot_list_q[idx_q] == lsel_q);
	assign stat.slot_ok    = cur_valid && (slot_list_q[idx_q] == lsel_q)
		&& (end_pos <= 10'(pkt_cnt_q));
	assign stat.bytes_done = (kcnt_q == cur_fld.len);

	ftc_ram #(.WIDTH(8), .DEPTH(PACKET_BYTES)) u_pkt_ram (
		.clk   (clk),
		.we    (byte_wr),
		.waddr (AW'(pkt_cnt_q)),
		.wdata (item.pkt_byte),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
			ins_cnt_q    <= '0;
			pkt_cnt_q    <= '0;
		end else begin
			if (free_now) begin
				slot_valid_q[idx_q] <= 1'b0;
				if (ins_cnt_q != '0) begin
					ins_cnt_q <= ins_cnt_q - CNTW'(1);
				end
			end
			if (add_now) begin
				slot_valid_q[free_slot_q] <= 1'b1;
				ins_cnt_q                 <= ins_cnt_q + CNTW'(1);
			end
			if (byte_wr) begin
				pkt_cnt_q <= pkt_cnt_q + PCW'(1);
			end
			if (cmd.op == DP_LK_END) begin
				pkt_cnt_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < TABLE_SLOTS; j++) begin
			if (free_now && slot_valid_q[j] && (slot_order_q[j] > cur_order)) begin
				slot_order_q[j] <= slot_order_q[j] - SW'(1);
			end
		end
		if (add_now) begin
			slot_list_q[free_slot_q]   <= lsel_q;
			slot_fields_q[free_slot_q] <= fld_q;
			slot_rule_q[free_slot_q]   <= val_q;
			slot_order_q[free_slot_q]  <= SW'(ins_cnt_q);
			slot_reload_q[free_slot_q] <= life_q;
			slot_rem_q[free_slot_q]    <= life_q;
		end
		if ((cmd.op == DP_TICK) && tick_live) begin
			slot_rem_q[idx_q] <= rem_dec;
		end
		if ((cmd.op == DP_LK_END) && best_vld_q && refresh) begin
			slot_rem_q[best_slot_q] <= best_reload_q;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			DP_LATCH: begin
				lsel_q           <= item.list_sel;
				fld_q            <= fld_n;
				val_q            <= val_n;
				life_q           <= item.lifetime;
				extl_q           <= item.ext_len;
				idx_q            <= '0;
				free_vld_q       <= 1'b0;
				found_q          <= 1'b0;
				best_vld_q       <= 1'b0;
				res_q.hit_slot   <= 4'd0;
				res_q.hit_action <= 3'd0;
				case (item.kind)
					KIND_ADD:    res_q.status <= ST_FULL;
					KIND_REMOVE: res_q.status <= ST_NOT_FOUND;
					default:     res_q.status <= ST_NO_MATCH;
				endcase
			end
			DP_DUP: begin
				idx_q <= idx_q + SW'(1);
				if (stat.dup_hit) begin
					res_q.status   <= ST_DUPLICATE;
					res_q.hit_slot <= 4'(idx_q);
				end
				if (!cur_valid && !free_vld_q) begin
					free_vld_q  <= 1'b1;
					free_slot_q <= idx_q;
				end
			end
			DP_ADD_WR: begin
				if (free_vld_q) begin
					res_q.status   <= ST_ADDED;
					res_q.hit_slot <= 4'(free_slot_q);
				end
			end
			DP_REM: begin
				idx_q <= idx_q + SW'(1);
				if (match_cur && !found_q) begin
					found_q        <= 1'b1;
					res_q.status   <= ST_REMOVED;
					res_q.hit_slot <= 4'(idx_q);
				end
			end
			DP_TICK: begin
				idx_q <= idx_q + SW'(1);
			end
			DP_LK_SLOT: begin
				if (stat.slot_ok) begin
					ptr_q  <= AW'(pos) + AW'(1);
					kcnt_q <= 4'd1;
					pv_q   <= '0;
				end else begin
					idx_q <= idx_q + SW'(1);
				end
			end
			DP_LK_BYTE: begin
				pv_q <= {pv_q[55:0], ram_rdata};
				if (!stat.bytes_done) begin
					ptr_q  <= ptr_q + AW'(1);
					kcnt_q <= kcnt_q + 4'd1;
				end
			end
			DP_LK_CMP: begin
				idx_q <= idx_q + SW'(1);
				if (holds && (!best_vld_q || (cur_order < best_ord_q))) begin
					best_vld_q    <= 1'b1;
					best_slot_q   <= idx_q;
					best_ord_q    <= cur_order;
					best_act_q    <= cur_fld.action;
					best_reload_q <= slot_reload_q[idx_q];
				end
			end
			DP_LK_END: begin
				if (best_vld_q) begin
					res_q.status     <= ST_HIT;
					res_q.hit_slot   <= 4'(best_slot_q);
					res_q.hit_action <= best_act_q;
				end
			end
			default: ;
		endcase
		if (cmd.load_out) begin
			out_q <= res_q;
		end
	end

	assign result = out_q;
endmodule

// ----- rtl/core/flow_table_classifier_top.sv -----
// ----------------------------------------------------------------------------
// Flow table classifier top level
// Two-list rule table with first-match packet lookup and rule ageing.
// ----------------------------------------------------------------------------
// One request is handled at a time. Add, remove and tick requests each scan
// the table, visiting one table slot per cycle, and an add scan stops early
// when it finds a duplicate. A lookup scan visits the slots the same way,
// but for every slot of the selected list that fits in the packet it stops
// to read that slot's match bytes from the packet buffer, one per cycle.
// A packet byte that is not last is written to the packet buffer while it
// has room; a last byte is also written and then starts the lookup. An add,
// a remove and a lookup each end by handing the response to the output
// register, waiting while the previous response there is not yet taken.
// A tick gives no response. A finished response waits in its own register
// while the next request is taken.
`include "flow_table_classifier_top_defines.svh"

module flow_table_classifier_top import ftc_pkg::*; #(
	parameter int TABLE_SLOTS     = TABLE_SLOTS_DEF,
	parameter int PACKET_BYTES    = PACKET_BYTES_DEF,
	parameter int MAX_MATCH_BYTES = MAX_MATCH_BYTES_DEF
) (
	input logic          clk,
	input logic          arst_n,
	ftc_stream_if.sink   cmd,
	ftc_stream_if.source rsp,
	ftc_stream_if.sink   cfg
);
	logic      refresh_q;
	ftc_stat_t stat;
	ftc_cmd_t  dp_cmd;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			refresh_q <= 1'b0;
		end else if (cfg.valid) begin
			refresh_q <= cfg.data;
		end
	end

	ftc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cmd.valid),
		.in_kind   (cmd.data.kind),
		.in_last   (cmd.data.last),
		.in_ready  (cmd.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.stat      (stat),
		.cmd       (dp_cmd)
	);

	ftc_dp #(
		.TABLE_SLOTS     (TABLE_SLOTS),
		.PACKET_BYTES    (PACKET_BYTES),
		.MAX_MATCH_BYTES (MAX_MATCH_BYTES)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (cmd.data),
		.refresh (refresh_q),
		.cmd     (dp_cmd),
		.stat    (stat),
		.result  (rsp.data)
	);

	`FTC_ASSERT_NEXT(a_busy_after_add, cmd.valid && cmd.ready && cmd.data.kind == KIND_ADD,
		!cmd.ready, "add request did not make the block busy")
	`FTC_ASSERT_NEXT(a_tick_silent, cmd.valid && cmd.ready && cmd.data.kind == KIND_TICK,
		!$rose(rsp.valid), "tick request produced a response")
	`FTC_ASSERT_NOW(a_miss_clean, rsp.valid && (rsp.data.status == ST_FULL
		|| rsp.data.status == ST_NOT_FOUND || rsp.data.status == ST_NO_MATCH),
		rsp.data.hit_slot == 4'd0 && rsp.data.hit_action == 3'd0,
		"response without a slot carries slot or action bits")
endmodule
